// ===== hw/rtl/sequential_list_engine_top_defines.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sle_pkg.sv =====
// Package with the types and codes of the sequential list engine.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int FUNC_W = 3;

  // Operation codes of the func field.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMMIN = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REMEQ  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_REMRNG = 3'd5;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIX_RD,
    S_FIX_WR,
    S_INS_WR,
    S_DONE
  } sle_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sequential_list_engine_top.sv =====
// Top level of the sequential list engine: sequencer, compare unit and element RAM.
// Flow: a rejected request, or a locate or remove equal on an empty list, goes straight to the
// result; an insert at the end first writes the new entry; other requests walk their span of
// live entries one per cycle, and remove minimum then moves the last entry into the freed slot.
// One request is in flight at a time: busy stays high until the result cycle ends.
// Reset clears the entry count and the sequencer; the element RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sequential_list_engine_top_defines.svh"

module sequential_list_engine_top
  import sle_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [DATA_W-1:0] in_item_value,
  input  wire logic signed [DATA_W-1:0] in_range_high,
  output logic                          out_strobe,
  output logic                          out_ok,
  output logic signed [DATA_W-1:0]      out_value,
  output logic [POS_W-1:0]              out_found_position,
  output logic [POS_W-1:0]              out_list_length
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam logic [CMP_W-1:0] CMP_ONE = CMP_W'(1);

  typedef struct packed {
    logic             scan;
    logic             ins_wr;
    logic             ok;
    logic             down;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] pos_idx;
  } sle_dec_t;

  sle_state_t state_r, state_nxt;

  logic [FUNC_W-1:0]        func_r, func_nxt;
  logic [IDX_W-1:0]         pos_idx_r, pos_idx_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic signed [DATA_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]         rd_end_r, rd_end_nxt;
  logic                     down_r, down_nxt;
  logic                     d_vld_r, d_vld_nxt;
  logic [IDX_W-1:0]         d_idx_r, d_idx_nxt;
  logic [CNT_W-1:0]         kept_r, kept_nxt;
  logic signed [DATA_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]         at_r, at_nxt;
  logic                     ok_r, ok_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;
  logic [POS_W-1:0]         found_r, found_nxt;

  logic                     accept;
  sle_dec_t                 dec;
  logic [CMP_W-1:0]         pos_w, cnt_w;
  logic [IDX_W-1:0]         cnt_m1;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic signed [DATA_W-1:0] ram_wdata, ram_rdata;

  logic signed [DATA_W-1:0] cmp_b;
  logic                     cmp_eq, cmp_lt, cmp_le_hi;
  logic                     keep;
  logic [CNT_W-1:0]         kept_after;

  assign accept = start && (state_r == S_IDLE);
  assign pos_w  = CMP_W'(in_position);
  assign cnt_w  = CMP_W'(cnt_r);
  assign cnt_m1 = IDX_W'(cnt_w - CMP_ONE);

  // Element store.
  sle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request decode: validity checks and the span of entries to walk.
  always_comb begin
    dec         = '0;
    dec.pos_idx = IDX_W'(pos_w - CMP_ONE);
    dec.last    = cnt_m1;
    case (in_func)
      FUNC_INSERT: begin
        if ((pos_w != '0) && (pos_w <= cnt_w + CMP_ONE) && (cnt_w < CMP_W'(CAPACITY))) begin
          dec.ok     = 1'b1;
          dec.down   = 1'b1;
          dec.first  = cnt_m1;
          dec.last   = dec.pos_idx;
          dec.scan   = (pos_w <= cnt_w);
          dec.ins_wr = (pos_w > cnt_w);
        end
      end
      FUNC_DELETE: begin
        if ((pos_w != '0) && (pos_w <= cnt_w)) begin
          dec.ok    = 1'b1;
          dec.scan  = 1'b1;
          dec.first = dec.pos_idx;
        end
      end
      FUNC_LOCATE: begin
        dec.scan = (cnt_r != '0);
      end
      FUNC_REMMIN: begin
        dec.ok   = (cnt_r != '0);
        dec.scan = (cnt_r != '0);
      end
      FUNC_REMEQ: begin
        dec.ok   = 1'b1;
        dec.scan = (cnt_r != '0);
      end
      FUNC_REMRNG: begin
        if ((in_item_value < in_range_high) && (cnt_r != '0)) begin
          dec.ok   = 1'b1;
          dec.scan = 1'b1;
        end
      end
      default: begin
        dec.ok = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (dec.scan) begin
            state_nxt = S_SCAN;
          end else if (dec.ins_wr) begin
            state_nxt = S_INS_WR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_r == rd_end_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (func_r == FUNC_INSERT) begin
          state_nxt = S_INS_WR;
        end else if (func_r == FUNC_REMMIN) begin
          state_nxt = S_FIX_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIX_RD: state_nxt = S_FIX_WR;
      S_FIX_WR: state_nxt = S_DONE;
      S_INS_WR: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, result strobe and RAM read address.
  always_comb begin
    busy       = (state_r != S_IDLE);
    out_strobe = (state_r == S_DONE);
    case (state_r)
      S_FIX_RD: ram_raddr = IDX_W'(cnt_w - CMP_ONE);
      default:  ram_raddr = rd_idx_r;
    endcase
  end

  // Shared compare unit on the word coming out of the RAM.
  always_comb begin
    cmp_b     = (func_r == FUNC_REMMIN) ? best_r : key_r;
    cmp_eq    = (ram_rdata == cmp_b);
    cmp_lt    = (ram_rdata < cmp_b);
    cmp_le_hi = (ram_rdata <= hi_r);
    case (func_r)
      FUNC_REMEQ:  keep = !cmp_eq;
      FUNC_REMRNG: keep = !(!cmp_lt && cmp_le_hi);
      default:     keep = 1'b0;
    endcase
    kept_after = keep ? (kept_r + CNT_W'(1)) : kept_r;
  end

  // Datapath: request capture, walk counter, per-entry work and RAM writes.
  always_comb begin
    func_nxt    = func_r;
    pos_idx_nxt = pos_idx_r;
    key_nxt     = key_r;
    hi_nxt      = hi_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    rd_end_nxt  = rd_end_r;
    down_nxt    = down_r;
    kept_nxt    = kept_r;
    best_nxt    = best_r;
    at_nxt      = at_r;
    ok_nxt      = ok_r;
    removed_nxt = removed_r;
    found_nxt   = found_r;
    d_vld_nxt   = (state_r == S_SCAN);
    d_idx_nxt   = rd_idx_r;
    ram_we      = 1'b0;
    ram_waddr   = d_idx_r;
    ram_wdata   = ram_rdata;

    // Capture an accepted request.
    if (accept) begin
      func_nxt    = in_func;
      pos_idx_nxt = dec.pos_idx;
      key_nxt     = in_item_value;
      hi_nxt      = in_range_high;
      rd_idx_nxt  = dec.first;
      rd_end_nxt  = dec.last;
      down_nxt    = dec.down;
      ok_nxt      = dec.ok;
      kept_nxt    = '0;
      removed_nxt = '0;
      found_nxt   = '0;
    end

    // Step the read index toward the end of the span.
    if ((state_r == S_SCAN) && (rd_idx_r != rd_end_r)) begin
      rd_idx_nxt = down_r ? (rd_idx_r - IDX_ONE) : (rd_idx_r + IDX_ONE);
    end

    // Work on the entry read in the previous cycle.
    if (d_vld_r) begin
      case (func_r)
        FUNC_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = d_idx_r + IDX_ONE;
        end
        FUNC_DELETE: begin
          if (d_idx_r == pos_idx_r) begin
            removed_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = d_idx_r - IDX_ONE;
          end
        end
        FUNC_LOCATE: begin
          if (cmp_eq && (found_r == '0)) begin
            found_nxt = POS_W'(CMP_W'(d_idx_r) + CMP_ONE);
            ok_nxt    = 1'b1;
          end
        end
        FUNC_REMMIN: begin
          if ((d_idx_r == '0) || cmp_lt) begin
            best_nxt = ram_rdata;
            at_nxt   = d_idx_r;
          end
        end
        FUNC_REMEQ, FUNC_REMRNG: begin
          if (keep) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(kept_r);
          end
          kept_nxt = kept_after;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end

    // Wrap-up writes and count updates.
    case (state_r)
      S_DRAIN: begin
        if (func_r == FUNC_DELETE) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if ((func_r == FUNC_REMEQ) || (func_r == FUNC_REMRNG)) begin
          cnt_nxt = kept_after;
        end
      end
      S_FIX_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = at_r;
        ram_wdata   = ram_rdata;
        removed_nxt = best_r;
        cnt_nxt     = cnt_r - CNT_W'(1);
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_idx_r;
        ram_wdata = key_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      default: begin
        cnt_nxt = cnt_nxt;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      d_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      d_vld_r <= d_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    pos_idx_r <= pos_idx_nxt;
    key_r     <= key_nxt;
    hi_r      <= hi_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_end_r  <= rd_end_nxt;
    down_r    <= down_nxt;
    d_idx_r   <= d_idx_nxt;
    kept_r    <= kept_nxt;
    best_r    <= best_nxt;
    at_r      <= at_nxt;
    ok_r      <= ok_nxt;
    removed_r <= removed_nxt;
    found_r   <= found_nxt;
  end

  // Result ports.
  assign out_ok             = ok_r;
  assign out_value          = removed_r;
  assign out_found_position = found_r;
  assign out_list_length    = POS_W'(cnt_r);

  // Checks on the sequencer and the result.
  `SLE_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
  `SLE_ASSERT_NEXT(a_done_idle, out_strobe, !busy && !out_strobe, "result not followed by idle")
  `SLE_ASSERT_NOW(a_we_busy, ram_we, busy, "RAM write while idle")
  `SLE_ASSERT_NOW(a_reject_zero, out_strobe && !out_ok, out_value == '0,
                  "rejected request returned a value")
  `SLE_ASSERT_NOW(a_data_after_read, d_vld_r, $past(state_r == S_SCAN),
                  "read data without a read")

endmodule

`default_nettype wire
